>>> rtl/cau_pkg.sv
// shared types, constants and helpers of the complex arithmetic unit
package cau_pkg;

  localparam int DataWidth  = 16;
  localparam int FracBits   = 8;
  localparam int ProdWidth  = 2 * DataWidth;
  localparam int DenWidth   = ProdWidth;
  localparam int NumWidth   = ProdWidth + FracBits;
  localparam int QuotWidth  = DataWidth + 1;
  localparam int SqRemWidth = DataWidth + 4;
  localparam int Steps      = DataWidth;
  localparam int PipeDepth  = Steps + 3;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIV0    = 2'd1,
    ST_SAT     = 2'd2
  } status_t;

  typedef struct packed {
    logic                 re_neg;
    logic                 im_neg;
    logic                 ovf_re;
    logic                 ovf_im;
    logic                 div0;
    logic [2:0]           op;
  } ctl_t;

  // one word moving down the cell chain
  typedef struct packed {
    ctl_t                  ctl;
    logic [DenWidth-1:0]   den;
    logic [DenWidth-1:0]   rem_re;
    logic [DenWidth-1:0]   rem_im;
    logic [DataWidth-1:0]  lo_re;
    logic [DataWidth-1:0]  lo_im;
    logic [DataWidth-1:0]  q_re;
    logic [DataWidth-1:0]  q_im;
    logic [ProdWidth-1:0]  sq_x;
    logic [SqRemWidth-1:0] sq_rem;
    logic [DataWidth-1:0]  sq_res;
  } lane_t;

  // clamp a sign and magnitude to the data range
  function automatic logic [DataWidth:0] pack_sat(input logic neg,
                                                  input logic [QuotWidth-1:0] mag);
    logic [QuotWidth-1:0] lim;
    logic [DataWidth-1:0] val;
    logic                 sat;
    begin
      lim = neg ? (QuotWidth'(1) << (DataWidth - 1))
                : ((QuotWidth'(1) << (DataWidth - 1)) - 1'b1);
      sat = mag > lim;
      val = sat ? lim[DataWidth-1:0] : mag[DataWidth-1:0];
      if (neg) val = -val;
      pack_sat = {sat, val};
    end
  endfunction

endpackage

>>> rtl/cau_if.sv
// valid/ready channel carrying one payload word
interface cau_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/complex_arithmetic_unit.sv
// complex arithmetic unit: operand stages, divide/sqrt cell chain, output register
//  channel   dir  fields
//  in_ch     in   op, a_re, a_im, b_re, b_im
//  out_ch    out  res_re, res_im, status
// one word per cycle in and out while out_ch.ready stays high
// an input word, once taken, passes to its result word through the registers of:
//   two operand stages, sixteen cells and the output register
// whole pipe and in_ch.ready hold while a valid result word is not taken
// rst clears valid bits only and keeps in_ch.ready low
module complex_arithmetic_unit (
  input logic clk,
  input logic rst,
  cau_if.sink   in_ch,
  cau_if.source out_ch
);
  logic en;
  logic [cau_pkg::PipeDepth-1:0] vld;
  cau_pkg::lane_t lane [0:cau_pkg::Steps];

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en && !rst;

  cau_front u_front (
    .clk(clk), .en(en), .op(in_ch.data.op),
    .a_re(in_ch.data.a_re), .a_im(in_ch.data.a_im),
    .b_re(in_ch.data.b_re), .b_im(in_ch.data.b_im),
    .dout(lane[0])
  );

  for (genvar i = 0; i < cau_pkg::Steps; i++) begin : g_cell
    cau_cell u_cell (.clk(clk), .en(en), .din(lane[i]), .dout(lane[i+1]));
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[cau_pkg::PipeDepth-2:0], in_ch.valid};
  end

  logic [cau_pkg::DataWidth:0] pre, pim;
  cau_pkg::ctl_t c;
  always_comb begin
    c = lane[cau_pkg::Steps].ctl;
    pre = cau_pkg::pack_sat(c.re_neg, {c.ovf_re, lane[cau_pkg::Steps].q_re});
    pim = cau_pkg::pack_sat(c.im_neg, {c.ovf_im, lane[cau_pkg::Steps].q_im});
    if (c.op == cau_pkg::OP_MOD) begin
      pre = {1'b0, 1'b0, lane[cau_pkg::Steps].sq_res[cau_pkg::DataWidth-2:0]};
      if (lane[cau_pkg::Steps].sq_res[cau_pkg::DataWidth-1])
        pre = {1'b1, 1'b0, {(cau_pkg::DataWidth-1){1'b1}}};
      pim = '0;
    end
    if (c.div0 || c.op > cau_pkg::OP_MOD) begin
      pre = '0;
      pim = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.data.res_re <= pre[cau_pkg::DataWidth-1:0];
      out_ch.data.res_im <= pim[cau_pkg::DataWidth-1:0];
      out_ch.data.status <= c.div0 ? cau_pkg::ST_DIV0
                          : (pre[cau_pkg::DataWidth] || pim[cau_pkg::DataWidth]) ? cau_pkg::ST_SAT
                          : cau_pkg::ST_OK;
    end
  end
  assign out_ch.valid = vld[cau_pkg::PipeDepth-1];

  assert property (@(posedge clk) disable iff (rst) out_ch.valid && !out_ch.ready |=> out_ch.valid);
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.data)) else $error("word changed in stall");
  assert property (@(posedge clk) disable iff (rst) !en |-> out_ch.valid)
    else $error("stall without pending word");
  assert property (@(posedge clk) rst |-> !in_ch.ready) else $error("ready during reset");
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.data.status <= 2'(cau_pkg::ST_SAT)) else $error("bad status");
endmodule

>>> rtl/cau_cell.sv
// one cell: a restoring divide step on both parts and a square-root step
module cau_cell (
  input  logic           clk,
  input  logic           en,
  input  cau_pkg::lane_t din,
  output cau_pkg::lane_t dout
);
  cau_pkg::lane_t dout_next;
  logic [cau_pkg::DenWidth:0]     tr_re;
  logic [cau_pkg::DenWidth:0]     tr_im;
  logic [cau_pkg::SqRemWidth-1:0] sq_t;
  logic [cau_pkg::SqRemWidth-1:0] sq_trial;

  always_comb begin
    dout_next = din;
    tr_re = {din.rem_re, din.lo_re[cau_pkg::DataWidth-1]};
    tr_im = {din.rem_im, din.lo_im[cau_pkg::DataWidth-1]};
    dout_next.lo_re = {din.lo_re[cau_pkg::DataWidth-2:0], 1'b0};
    dout_next.lo_im = {din.lo_im[cau_pkg::DataWidth-2:0], 1'b0};
    dout_next.q_re = {din.q_re[cau_pkg::DataWidth-2:0], 1'b0};
    dout_next.q_im = {din.q_im[cau_pkg::DataWidth-2:0], 1'b0};
    if (tr_re >= {1'b0, din.den}) begin
      tr_re = tr_re - {1'b0, din.den};
      dout_next.q_re[0] = 1'b1;
    end
    if (tr_im >= {1'b0, din.den}) begin
      tr_im = tr_im - {1'b0, din.den};
      dout_next.q_im[0] = 1'b1;
    end
    dout_next.rem_re = tr_re[cau_pkg::DenWidth-1:0];
    dout_next.rem_im = tr_im[cau_pkg::DenWidth-1:0];
    // root step on the next two bits of the sum of squares
    sq_t = {din.sq_rem[cau_pkg::SqRemWidth-3:0], din.sq_x[cau_pkg::ProdWidth-1 -: 2]};
    sq_trial = (cau_pkg::SqRemWidth)'({din.sq_res, 2'b01});
    dout_next.sq_x = {din.sq_x[cau_pkg::ProdWidth-3:0], 2'b00};
    dout_next.sq_res = {din.sq_res[cau_pkg::DataWidth-2:0], 1'b0};
    if (sq_t >= sq_trial) begin
      sq_t = sq_t - sq_trial;
      dout_next.sq_res[0] = 1'b1;
    end
    dout_next.sq_rem = sq_t;
  end

  always_ff @(posedge clk) begin
    if (en) dout <= dout_next;
  end
endmodule

>>> rtl/cau_front.sv
// operand stages: products and sums, then signs, magnitudes, divisor and chain seed
module cau_front (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [2:0]                           op,
  input  logic signed [cau_pkg::DataWidth-1:0] a_re,
  input  logic signed [cau_pkg::DataWidth-1:0] a_im,
  input  logic signed [cau_pkg::DataWidth-1:0] b_re,
  input  logic signed [cau_pkg::DataWidth-1:0] b_im,
  output cau_pkg::lane_t                       dout
);
  logic signed [cau_pkg::ProdWidth-1:0] arbr, aibi, arbi, aibr, arar, aiai, brbr, bibi;
  logic signed [cau_pkg::DataWidth:0]   sre, sim;
  logic [2:0]                           opcode;
  logic signed [cau_pkg::ProdWidth+1:0] vre, vim;
  logic [cau_pkg::ProdWidth:0]          mre, mim;
  logic [cau_pkg::NumWidth-1:0]         xre, xim;
  logic [cau_pkg::DenWidth-1:0]         den, dsel;
  cau_pkg::lane_t                       dout_next;

  always_ff @(posedge clk) begin
    if (en) begin
      arbr <= (cau_pkg::ProdWidth)'(a_re) * (cau_pkg::ProdWidth)'(b_re);
      aibi <= (cau_pkg::ProdWidth)'(a_im) * (cau_pkg::ProdWidth)'(b_im);
      arbi <= (cau_pkg::ProdWidth)'(a_re) * (cau_pkg::ProdWidth)'(b_im);
      aibr <= (cau_pkg::ProdWidth)'(a_im) * (cau_pkg::ProdWidth)'(b_re);
      arar <= (cau_pkg::ProdWidth)'(a_re) * (cau_pkg::ProdWidth)'(a_re);
      aiai <= (cau_pkg::ProdWidth)'(a_im) * (cau_pkg::ProdWidth)'(a_im);
      brbr <= (cau_pkg::ProdWidth)'(b_re) * (cau_pkg::ProdWidth)'(b_re);
      bibi <= (cau_pkg::ProdWidth)'(b_im) * (cau_pkg::ProdWidth)'(b_im);
      sre  <= (op == cau_pkg::OP_SUB)
              ? (cau_pkg::DataWidth+1)'(a_re) - (cau_pkg::DataWidth+1)'(b_re)
              : (cau_pkg::DataWidth+1)'(a_re) + (cau_pkg::DataWidth+1)'(b_re);
      sim  <= (op == cau_pkg::OP_SUB)
              ? (cau_pkg::DataWidth+1)'(a_im) - (cau_pkg::DataWidth+1)'(b_im)
              : (cau_pkg::DataWidth+1)'(a_im) + (cau_pkg::DataWidth+1)'(b_im);
      opcode <= op;
    end
  end

  always_comb begin
    den  = $unsigned(brbr) + $unsigned(bibi);
    dsel = (cau_pkg::DenWidth)'(1);
    vre  = '0;
    vim  = '0;
    case (opcode)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        vre = (cau_pkg::ProdWidth+2)'(sre);
        vim = (cau_pkg::ProdWidth+2)'(sim);
      end
      cau_pkg::OP_MUL: begin
        vre  = (cau_pkg::ProdWidth+2)'(arbr) - (cau_pkg::ProdWidth+2)'(aibi);
        vim  = (cau_pkg::ProdWidth+2)'(arbi) + (cau_pkg::ProdWidth+2)'(aibr);
        dsel = (cau_pkg::DenWidth)'(1) << cau_pkg::FracBits;
      end
      cau_pkg::OP_DIV: begin
        vre = (cau_pkg::ProdWidth+2)'(arbr) + (cau_pkg::ProdWidth+2)'(aibi);
        vim = (cau_pkg::ProdWidth+2)'(aibr) - (cau_pkg::ProdWidth+2)'(arbi);
        if (den != '0) dsel = den;
      end
      default: begin
      end
    endcase
    mre = vre[cau_pkg::ProdWidth+1] ? (cau_pkg::ProdWidth+1)'(-vre)
                                    : (cau_pkg::ProdWidth+1)'(vre);
    mim = vim[cau_pkg::ProdWidth+1] ? (cau_pkg::ProdWidth+1)'(-vim)
                                    : (cau_pkg::ProdWidth+1)'(vim);
    xre = (cau_pkg::NumWidth)'(mre);
    xim = (cau_pkg::NumWidth)'(mim);
    if (opcode == cau_pkg::OP_DIV) begin
      xre = xre << cau_pkg::FracBits;
      xim = xim << cau_pkg::FracBits;
    end
    dout_next            = '0;
    dout_next.ctl.op     = opcode;
    dout_next.ctl.re_neg = vre[cau_pkg::ProdWidth+1];
    dout_next.ctl.im_neg = vim[cau_pkg::ProdWidth+1];
    dout_next.ctl.div0   = (opcode == cau_pkg::OP_DIV) && (den == '0);
    dout_next.den        = dsel;
    // quotient of 2^DataWidth or more only ever saturates
    dout_next.rem_re     = (cau_pkg::DenWidth)'(xre[cau_pkg::NumWidth-1:cau_pkg::DataWidth]);
    dout_next.rem_im     = (cau_pkg::DenWidth)'(xim[cau_pkg::NumWidth-1:cau_pkg::DataWidth]);
    dout_next.ctl.ovf_re = dout_next.rem_re >= dsel;
    dout_next.ctl.ovf_im = dout_next.rem_im >= dsel;
    dout_next.lo_re      = xre[cau_pkg::DataWidth-1:0];
    dout_next.lo_im      = xim[cau_pkg::DataWidth-1:0];
    dout_next.sq_x       = (opcode == cau_pkg::OP_MOD) ? $unsigned(arar) + $unsigned(aiai) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) dout <= dout_next;
  end
endmodule
